FILE: hw/rtl/sldf_pkg.sv
// Shared types and constants for the sync/length frame deframer.
package sldf_pkg;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 5;
  localparam int TOTAL_W = 6;
  localparam int LEN_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [TOTAL_W-1:0] HEADER_BYTES = 6'd3;
  localparam int                 PAYLOAD_CAP  = 29;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 5'd29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_PAYLOAD = 2'd2
  } cfg_index_t;

  // Descriptor of one completed frame: header plus payload byte count.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
  } desc_t;

  typedef struct packed {
    logic  valid;
    logic  full;
    desc_t head;
  } q_status_t;

endpackage

FILE: hw/rtl/sldf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sldf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/sldf_queue.sv
// Two-entry queue of completed-frame descriptors between parser and drain.
module sldf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sldf_pkg::desc_t   push_desc,
  input  logic              pop,
  output sldf_pkg::q_status_t status
);
  import sldf_pkg::*;

  desc_t      entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      entry[wp] <= push_desc;
    end
  end

  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'd2);
  assign status.head  = entry[rp];

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full || pop)
    else $error("descriptor pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> status.valid)
    else $error("descriptor popped from empty queue");

endmodule

FILE: hw/rtl/sldf_front.sv
// Byte parser: sync hunt, length check, frame store writes, descriptor push.
module sldf_front #(
  parameter int FRAME_BYTES = 32,
  parameter int AW          = $clog2(FRAME_BYTES)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sldf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sldf_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sldf_pkg::BYTE_W-1:0]    in_byte,
  input  sldf_pkg::q_status_t            q_status,
  output logic                           push,
  output sldf_pkg::desc_t                push_desc,
  output logic                           st_we,
  output logic [AW:0]                    st_addr,
  output logic [sldf_pkg::BYTE_W-1:0]    st_data
);
  import sldf_pkg::*;

  localparam int FB_CAP = FRAME_BYTES - 3;
  localparam logic [LEN_W-1:0] LEN_CAP =
    (FB_CAP < PAYLOAD_CAP) ? LEN_W'(FB_CAP) : LEN_W'(PAYLOAD_CAP);

  logic [BYTE_W-1:0]  sync_first;
  logic [BYTE_W-1:0]  sync_second;
  logic [LEN_W-1:0]   max_payload;
  logic [TOTAL_W-1:0] fill;
  logic [LEN_W-1:0]   plen;
  logic               bank;

  logic               accept;
  logic [LEN_W-1:0]   limit;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] fill_inc;
  logic               len_bad;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign limit    = (max_payload > LEN_CAP) ? LEN_CAP : max_payload;
  assign total    = TOTAL_W'(plen) + HEADER_BYTES;
  assign fill_inc = fill + 6'd1;
  assign len_bad  = (in_byte == '0) || (in_byte > BYTE_W'(limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        CFG_MAX_PAYLOAD: max_payload <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_we = 1'b0;
    push  = 1'b0;
    if (accept) begin
      case (fill)
        6'd0:    st_we = (in_byte == sync_first);
        6'd1:    st_we = (in_byte == sync_second);
        6'd2:    st_we = !len_bad;
        default: begin
          st_we = 1'b1;
          push  = (fill_inc >= total);
        end
      endcase
    end
  end

  assign st_addr         = {bank, AW'(fill)};
  assign st_data         = in_byte;
  assign push_desc.total = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      plen <= '0;
      bank <= 1'b0;
    end else if (accept) begin
      case (fill)
        6'd0: fill <= (in_byte == sync_first) ? 6'd1 : 6'd0;
        // mismatch drops to hunting; the byte is not retried as a first sync
        6'd1: fill <= (in_byte == sync_second) ? 6'd2 : 6'd0;
        6'd2: begin
          if (len_bad) begin
            fill <= '0;
          end else begin
            fill <= 6'd3;
            plen <= in_byte[LEN_W-1:0];
          end
        end
        default: begin
          if (fill_inc >= total) begin
            fill <= '0;
            bank <= ~bank;
          end else begin
            fill <= fill_inc;
          end
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill >= 6'd3) |-> (fill < total))
    else $error("fill count ran past frame length");

endmodule

FILE: hw/rtl/sldf_back.sv
// Frame drain: reads a completed frame from the store, one byte per request.
module sldf_back #(
  parameter int FRAME_BYTES = 32,
  parameter int AW          = $clog2(FRAME_BYTES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sldf_pkg::q_status_t         q_status,
  output logic                        pop,
  output logic                        rd_en,
  output logic [AW:0]                 rd_addr,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sldf_pkg::POS_W-1:0]  out_pos,
  output logic                        out_last
);
  import sldf_pkg::*;

  logic             bank;
  logic [POS_W-1:0] k;
  logic             last_k;

  // the RAM read register is the output data register, so a read is only
  // issued when the current output is free or being taken
  assign rd_en   = q_status.valid && (!out_valid || out_ready);
  assign last_k  = ((TOTAL_W'(k) + 6'd1) == q_status.head.total);
  assign pop     = rd_en && last_k;
  assign rd_addr = {bank, AW'(k)};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      bank      <= 1'b0;
      k         <= '0;
    end else if (rd_en) begin
      out_valid <= 1'b1;
      if (last_k) begin
        k    <= '0;
        bank <= ~bank;
      end else begin
        k <= k + 5'd1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (rd_en) begin
      out_pos  <= k;
      out_last <= last_k;
    end
  end

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (rd_en && !last_k) |=> (k == $past(k) + 5'd1))
    else $error("drain position skipped");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !rd_en)
    else $error("store read while output stalled");

endmodule

FILE: hw/rtl/sync_length_frame_deframer.sv
// Top level of the two-byte sync, length-prefixed frame deframer.
//
// s_tdata carries one received byte per request. The parser hunts for
// sync_first then sync_second, takes the third byte as payload length and
// stores header plus payload. When the frame is complete it is emitted on the
// master side, one byte per request, header first; m_tlast marks the final
// byte. Configuration is to be written through cfg_we/cfg_index/cfg_data while
// idle; the block itself does not enforce this. Input: one byte per cycle
// while s_tready is high. s_tready drops only when two completed frames are
// still waiting to drain (two-bank frame store with a two-entry descriptor
// queue). Output: a completed frame's descriptor is pushed into the queue,
// then its bytes are read into the store read register, which holds the
// output byte; the next byte is read as the current one is taken, a rate set
// by the single store read port. Reset clears the parser to hunting, the
// queue and the output valid, and restores the register defaults. If the
// receiver stalls, the output byte holds and the drain pauses; the parser
// keeps taking bytes until the queue fills.
module sync_length_frame_deframer #(
  parameter int FRAME_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] rx_value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // [7:0] frame_value,
                                                    // [12:8] frame_position
  output logic                           m_tlast,   // last_of_frame
  input  logic                           cfg_we,
  input  logic [sldf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sldf_pkg::BYTE_W-1:0]    cfg_data
);
  import sldf_pkg::*;

  localparam int AW        = $clog2(FRAME_BYTES);
  localparam int RAM_DEPTH = 2 * (2 ** AW);

  q_status_t         q_status;
  desc_t             push_desc;
  logic              push;
  logic              pop;
  logic              st_we;
  logic [AW:0]       st_addr;
  logic [BYTE_W-1:0] st_data;
  logic              rd_en;
  logic [AW:0]       rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [POS_W-1:0]  out_pos;

  sldf_front #(.FRAME_BYTES(FRAME_BYTES), .AW(AW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_desc (push_desc),
    .st_we     (st_we),
    .st_addr   (st_addr),
    .st_data   (st_data)
  );

  sldf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .status    (q_status)
  );

  sldf_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_addr),
    .wdata (st_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sldf_back #(.FRAME_BYTES(FRAME_BYTES), .AW(AW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop       (pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pos   (out_pos),
    .out_last  (m_tlast)
  );

  assign m_tdata = {3'b000, out_pos, rd_data};

endmodule

FILE: dv/tb_sync_length_frame_deframer.sv
// Self-checking testbench for the sync/length frame deframer top level.
`timescale 1ns / 1ps

module tb_sync_length_frame_deframer;
  import sldf_pkg::*;

  localparam int                   STORE_DEPTH    = 32;
  localparam int                   CYCLE_LIMIT    = 200000;
  localparam int                   DRAIN_CYCLES   = 40;
  localparam int                   PHASE_REQUESTS = 44;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_byte_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [15:0]       m_tdata;
  logic              m_tlast;
  logic              cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data  = '0;

  sync_length_frame_deframer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Deframer shadow state and registers
  logic [BYTE_W-1:0] sync1_r;
  logic [BYTE_W-1:0] sync2_r;
  logic [LEN_W-1:0]  maxlen_r;
  logic [5:0]        held_count;
  logic [LEN_W-1:0]  held_len;
  logic [BYTE_W-1:0] held_bytes [STORE_DEPTH];

  frame_byte_t frame_bytes_due[$];

  int fail_count     = 0;
  int cycle_count    = 0;
  int parsed_count   = 0;
  int frames_emitted = 0;
  int bytes_checked  = 0;
  int burst_left     = 0;

  function automatic int unsigned len_limit();
    return (maxlen_r > PAYLOAD_CAP) ? PAYLOAD_CAP : maxlen_r;
  endfunction

  function automatic void hold_byte(input logic [BYTE_W-1:0] b);
    if (held_count < STORE_DEPTH) held_bytes[held_count[4:0]] = b;
    held_count = held_count + 6'd1;
  endfunction

  // Advance the shadow parser by one byte; queue the frame when it completes.
  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    int unsigned total;
    frame_byte_t fb;
    parsed_count++;
    if (held_count == 0) begin
      if (b == sync1_r) begin
        hold_byte(b);
      end
    end else if (held_count == 1) begin
      if (b == sync2_r) hold_byte(b);
      else held_count = '0;
    end else if (held_count == 2) begin
      if (b == 0 || b > len_limit()) begin
        held_count = '0;
      end else begin
        held_len = b[LEN_W-1:0];
        hold_byte(b);
      end
    end else begin
      hold_byte(b);
      total = held_len + HEADER_BYTES;
      if (held_count >= total) begin
        held_count = '0;
        frames_emitted++;
        for (int k = 0; k < total; k++) begin
          fb.value = held_bytes[k[4:0]];
          fb.pos   = k[POS_W-1:0];
          fb.last  = (k + 1 == total);
          frame_bytes_due.push_back(fb);
        end
      end
    end
  endfunction

  // Receiver: ready pattern switches between always-ready, random and long stalls
  int unsigned rx_mode    = 0;
  int unsigned rx_seg     = 0;
  int unsigned rx_run     = 0;

  always @(negedge clk) begin
    if (rx_seg == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_seg  <= $urandom_range(16, 96);
    end else begin
      rx_seg <= rx_seg - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_run == 0) begin
          m_tready <= !m_tready;
          rx_run   <= m_tready ? $urandom_range(1, 40) : $urandom_range(1, 8);
        end else begin
          rx_run <= rx_run - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (frame_bytes_due.size() == 0) begin
        $error("frame byte with none pending: data %h last %b", m_tdata, m_tlast);
        fail_count++;
      end else begin
        frame_byte_t exp_b;
        exp_b = frame_bytes_due.pop_front();
        bytes_checked++;
        if (m_tdata[7:0] !== exp_b.value) begin
          $error("frame_value: expected %h, got %h", exp_b.value, m_tdata[7:0]);
          fail_count++;
        end
        if (m_tdata[12:8] !== exp_b.pos) begin
          $error("frame_position: expected %0d, got %0d", exp_b.pos, m_tdata[12:8]);
          fail_count++;
        end
        if (m_tlast !== exp_b.last) begin
          $error("last_of_frame: expected %b, got %b", exp_b.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Sender works in bursts; a gap lowers tvalid for a random number of cycles.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] len);
    send_byte(sync1_r);
    send_byte(sync2_r);
    send_byte(len);
    for (int i = 0; i < len; i++) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Drain everything pending, then leave the block a few quiet cycles.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SYNC_FIRST:  sync1_r  = val;
      CFG_SYNC_SECOND: sync2_r  = val;
      CFG_MAX_PAYLOAD: maxlen_r = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_default_frames();
    send_frame(8'd1);
    // rejected lengths: zero and one past the cap
    send_byte(sync1_r); send_byte(sync2_r); send_byte(8'd0);
    send_byte(sync1_r); send_byte(sync2_r); send_byte(8'd30);
    // bad second byte equal to the first sync is not re-tested
    send_byte(8'hAA); send_byte(8'hAA); send_byte(8'h55);
    send_byte(sync1_r); send_byte(sync2_r); send_byte(8'd2);
    send_byte(8'h00); send_byte(8'h80);
  endtask

  task automatic test_config_extremes();
    settle();
    set_reg(CFG_SYNC_FIRST, 8'h00);
    set_reg(CFG_SYNC_SECOND, 8'hFF);
    set_reg(CFG_MAX_PAYLOAD, 8'd1);
    set_reg(CFG_UNUSED_IDX, 8'h12);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'd1); send_byte(8'h7F);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'd2);
  endtask

  task automatic random_phase(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                              input logic [BYTE_W-1:0] maxv);
    int start;
    int unsigned pick;
    int unsigned lim;
    logic [BYTE_W-1:0] v;
    settle();
    set_reg(CFG_SYNC_FIRST, s1);
    set_reg(CFG_SYNC_SECOND, s2);
    set_reg(CFG_MAX_PAYLOAD, maxv);
    lim   = len_limit();
    start = parsed_count;
    if (lim != 0) send_frame(BYTE_W'(lim));
    while (parsed_count - start < PHASE_REQUESTS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // with a zero limit every length is rejected; a short tail keeps the byte count down
        if (lim == 0) send_frame(BYTE_W'($urandom_range(1, 5)));
        else if (pick == 0) send_frame(BYTE_W'(lim));
        else send_frame(BYTE_W'($urandom_range(1, (lim < 5) ? lim : 5)));
      end else if (pick == 6) begin
        // broken header: wrong second byte
        v = ($urandom_range(0, 1) != 0) ? sync1_r : BYTE_W'($urandom_range(0, 255));
        if (v == sync2_r) v = sync2_r + 8'd1;
        send_byte(sync1_r);
        send_byte(v);
      end else if (pick == 7) begin
        send_byte(sync1_r);
        send_byte(sync2_r);
        send_byte(($urandom_range(0, 3) == 0) ? 8'd0 : BYTE_W'($urandom_range(lim + 1, 255)));
      end else if (pick == 8 && lim > 1) begin
        // truncated frame; following bytes land in its payload
        v = BYTE_W'($urandom_range(2, lim));
        send_byte(sync1_r);
        send_byte(sync2_r);
        send_byte(v);
        repeat ($urandom_range(0, v - 1)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_random_phases();
    random_phase(8'hAA, 8'h55, 8'hFF);   // masked to 31, above the cap, so the cap of 29 applies
    random_phase(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)), 8'd30);
    random_phase(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)), 8'd0);
    random_phase(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)), 8'd1);
    random_phase(8'h3C, 8'h3C, BYTE_W'($urandom_range(1, 29)));
    random_phase(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 BYTE_W'($urandom_range(1, 29)));
  endtask

  initial begin
    sync1_r    = SYNC_FIRST_RESET;
    sync2_r    = SYNC_SECOND_RESET;
    maxlen_r   = MAX_PAYLOAD_RESET;
    held_count = '0;
    held_len   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_frames();
    test_config_extremes();
    test_random_phases();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input bytes over 8 register settings, %0d frames emitted",
             parsed_count, frames_emitted);
    $display("Checked %0d frame bytes under random sender gaps and receiver stalls",
             bytes_checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sync_length_frame_deframer.f
hw/rtl/sldf_pkg.sv
hw/rtl/sldf_ram.sv
hw/rtl/sldf_queue.sv
hw/rtl/sldf_front.sv
hw/rtl/sldf_back.sv
hw/rtl/sync_length_frame_deframer.sv
dv/tb_sync_length_frame_deframer.sv
